// ----- rtl/core/pn2d_pkg.sv -----
// package for the 2d gradient noise sampler
// holds widths, mix constants, sequencer states and shared helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pn2d_pkg;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned TableBits = 8;
  localparam int unsigned TableSize = 256;
  localparam logic [31:0] Mix1 = 32'd3284157443;
  localparam logic [31:0] Mix2 = 32'd1911520717;
  localparam logic [31:0] Mix3 = 32'd2048419325;
  localparam logic [30:0] LcgMod = 31'h7fffffff;
  localparam logic [15:0] LcgMul = 16'd48271;

  localparam logic ReqBuild  = 1'b0;
  localparam logic ReqSample = 1'b1;
  localparam logic [0:0] RegSeed   = 1'b0;
  localparam logic [0:0] RegRepeat = 1'b1;

  typedef enum logic [4:0] {
    StIdle,
    StFill,
    StLcgMul,
    StLcgRed,
    StModStep,
    StPick,
    StSwap,
    StWrapX,
    StWrapY,
    StMixA,
    StMixB,
    StMixC,
    StRd0,
    StRd1,
    StRd2,
    StRd3,
    StFadeA,
    StFadeB,
    StLerpA,
    StLerpB,
    StLerpC,
    StDone
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } status_t;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    rot16 = {v[15:0], v[31:16]};
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/pn2d_divu.sv -----
// iterative restoring remainder unit, one quotient bit per cycle
// uses pn2d_pkg; shared by the pool draw and the cell wrap
`timescale 1ns / 1ps
`default_nettype none
module pn2d_divu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] num_i,
  input  wire logic [31:0] den_i,
  output pn2d_pkg::status_t stat_o,
  output logic [31:0]      rem_o
);
  logic [47:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [32:0] sh;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    sh = {rem_q[31:0], num_q[47]};
    trial = sh - {1'b0, den_q};
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0; cnt_d = 6'd48; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[46:0], 1'b0};
      rem_d = trial[32] ? sh : trial;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o = rem_q[31:0];
endmodule
`default_nettype wire

// ----- rtl/core/pn2d_mul.sv -----
// registered signed 33x33 multiplier shared by the lcg, hash mix, fade and blend
// does not use pn2d_pkg; no submodules
`timescale 1ns / 1ps
`default_nettype none
module pn2d_mul (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [65:0]      p_o
);
  logic signed [65:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end
  assign p_o = p_q;
endmodule
`default_nettype wire

// ----- rtl/core/perlin_noise_2d_sampler_top.sv -----
// top level of the 2d gradient noise sampler: sequencer, tables and stream ports
// uses pn2d_pkg, pn2d_mul and pn2d_divu
//
// channel  dir  beat fields (lsb first)
// s_axis   in   tdata: x_coord[31:0], y_coord[63:32]; tuser: req_type
// m_axis   out  tdata: noise_value[17:0]; tuser: table_built
// cfg      in   wr_en_i, wr_idx_i (0 seed, 1 repeat_period), wr_data_i
//
// a build fills the pool, then makes one draw per entry: an lcg step, a remainder
// from the shared remainder unit, a pick and a swap; a sample wraps the cells with
// four remainders when the repeat period is nonzero, then each corner takes three
// mix multiplies and three chained table reads, then the fade and the blend.
// reset clears control only; tables are undefined until the first build.
// s_axis_tready is high only while idle; a waiting result holds the block.
`timescale 1ns / 1ps
`default_nettype none
module perlin_noise_2d_sampler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // x_coord, y_coord
  input  wire logic        s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // noise_value, zero pad
  output logic             m_axis_tuser,  // table_built
  input  wire logic        wr_en_i,
  input  wire logic        wr_idx_i,
  input  wire logic [31:0] wr_data_i
);
  pn2d_pkg::state_e st_q, st_d;
  logic [31:0] seed_q;
  logic [16:0] rep_q;
  logic [7:0]  perm [pn2d_pkg::TableSize];
  logic [7:0]  pool [pn2d_pkg::TableSize];
  logic [7:0]  prd_q, pool_rd_q, pool_last_q;

  logic [31:0] lcg_q, x_q, y_q, ha_q, hb_q;
  logic signed [32:0] cx_q, cy_q, lx_q, ly_q, rx_q, uy_q;
  logic [8:0]  cnt_q;
  logic [7:0]  k_q, idx_q, r_q;
  logic [1:0]  corner_q, sub_q;
  logic [1:0]  grad_q [4];
  logic signed [33:0] ft_q, fty_q, t2_q, lo_q, hi_q, v_q;
  logic        wrap_neg_q;
  logic        req_q;
  logic [17:0] out_q;
  logic        out_built_q, out_v_q;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic        dv_start;
  logic [47:0] dv_num;
  logic [31:0] dv_den, dv_rem;
  pn2d_pkg::status_t dv_st;

  // seed reduced mod 2^31-1 and the lcg product folded mod 2^31-1
  logic [31:0] seed_m1, seed_m2, lcg_fold, lcg_next;
  assign seed_m1 = (seed_q >= {1'b0, pn2d_pkg::LcgMod}) ?
                   seed_q - {1'b0, pn2d_pkg::LcgMod} : seed_q;
  assign seed_m2 = (seed_m1 >= {1'b0, pn2d_pkg::LcgMod}) ?
                   seed_m1 - {1'b0, pn2d_pkg::LcgMod} : seed_m1;
  assign lcg_fold = {1'b0, mp[30:0]} + {16'b0, mp[46:31]};
  assign lcg_next = (lcg_fold >= {1'b0, pn2d_pkg::LcgMod}) ?
                    lcg_fold - {1'b0, pn2d_pkg::LcgMod} : lcg_fold;

  pn2d_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));
  pn2d_divu u_div (.clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
                   .stat_o(dv_st), .rem_o(dv_rem));

  logic [15:0] tx, ty;
  assign tx = x_q[15:0];
  assign ty = y_q[15:0];

  // corner cell and offsets
  logic signed [32:0] ccx, ccy;
  logic signed [17:0] dx, dy, dot [4];
  assign ccx = corner_q[0] ? rx_q : lx_q;
  assign ccy = corner_q[1] ? uy_q : ly_q;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [17:0] ddx, ddy;
      ddx = c[0] ? ($signed({2'b0, tx}) - 18'sd65536) : $signed({2'b0, tx});
      ddy = c[1] ? ($signed({2'b0, ty}) - 18'sd65536) : $signed({2'b0, ty});
      case (grad_q[c])
        2'd0: dot[c] = ddx;
        2'd1: dot[c] = -ddx;
        2'd2: dot[c] = ddy;
        default: dot[c] = -ddy;
      endcase
    end
    dx = '0; dy = '0;
  end

  // signed remainder of a cell by the period, truncating
  logic signed [32:0] wrap_src, wrap_abs, wrap_res;
  assign wrap_abs = wrap_src[32] ? -wrap_src : wrap_src;
  assign wrap_res = wrap_neg_q ? -$signed({1'b0, dv_rem}) : $signed({1'b0, dv_rem});

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      pn2d_pkg::StIdle:
        if (s_axis_tvalid && !out_v_q)
          st_d = (s_axis_tuser == pn2d_pkg::ReqBuild) ? pn2d_pkg::StFill : pn2d_pkg::StWrapX;
      pn2d_pkg::StFill:    if (cnt_q == 9'd255) st_d = pn2d_pkg::StLcgMul;
      pn2d_pkg::StLcgMul:  if (sub_q == 2'd1) st_d = pn2d_pkg::StLcgRed;
      pn2d_pkg::StLcgRed:  st_d = pn2d_pkg::StModStep;
      pn2d_pkg::StModStep: if (dv_st.done) st_d = pn2d_pkg::StPick;
      pn2d_pkg::StPick:    st_d = pn2d_pkg::StSwap;
      pn2d_pkg::StSwap:    st_d = (cnt_q == 9'd1) ? pn2d_pkg::StDone : pn2d_pkg::StLcgMul;
      pn2d_pkg::StWrapX:   if (rep_q == '0 || (dv_st.done && sub_q == 2'd1)) st_d = pn2d_pkg::StWrapY;
      pn2d_pkg::StWrapY:   if (rep_q == '0 || (dv_st.done && sub_q == 2'd1)) st_d = pn2d_pkg::StMixA;
      pn2d_pkg::StMixA:    if (sub_q == 2'd1) st_d = pn2d_pkg::StMixB;
      pn2d_pkg::StMixB:    if (sub_q == 2'd1) st_d = pn2d_pkg::StMixC;
      pn2d_pkg::StMixC:    if (sub_q == 2'd1) st_d = pn2d_pkg::StRd0;
      pn2d_pkg::StRd0:     st_d = pn2d_pkg::StRd1;
      pn2d_pkg::StRd1:     st_d = pn2d_pkg::StRd2;
      pn2d_pkg::StRd2:     st_d = pn2d_pkg::StRd3;
      pn2d_pkg::StRd3:     st_d = (corner_q == 2'd3) ? pn2d_pkg::StFadeA : pn2d_pkg::StMixA;
      pn2d_pkg::StFadeA:   if (sub_q == 2'd3) st_d = pn2d_pkg::StFadeB;
      pn2d_pkg::StFadeB:   if (sub_q == 2'd3) st_d = pn2d_pkg::StLerpA;
      pn2d_pkg::StLerpA:   if (sub_q == 2'd1) st_d = pn2d_pkg::StLerpB;
      pn2d_pkg::StLerpB:   if (sub_q == 2'd1) st_d = pn2d_pkg::StLerpC;
      pn2d_pkg::StLerpC:   if (sub_q == 2'd1) st_d = pn2d_pkg::StDone;
      pn2d_pkg::StDone:    st_d = pn2d_pkg::StIdle;
      default:             st_d = pn2d_pkg::StIdle;
    endcase
  end

  // shared unit operand select
  always_comb begin
    ma = '0; mb = '0; dv_start = 1'b0; dv_num = '0; dv_den = '0; wrap_src = '0;
    unique case (st_q)
      pn2d_pkg::StLcgMul: begin
        ma = $signed({2'b0, lcg_q[30:0]}); mb = $signed({17'b0, pn2d_pkg::LcgMul});
      end
      pn2d_pkg::StModStep: begin
        dv_num = {17'b0, lcg_q[30:0]}; dv_den = {23'b0, cnt_q};
        dv_start = !dv_st.busy && !dv_st.done;
      end
      pn2d_pkg::StWrapX, pn2d_pkg::StWrapY: begin
        wrap_src = (sub_q == 2'd0) ? ((st_q == pn2d_pkg::StWrapX) ? cx_q : cy_q)
                 : (((st_q == pn2d_pkg::StWrapX) ? lx_q : ly_q) + 33'sd1);
        dv_num = {15'b0, wrap_abs}; dv_den = {15'b0, rep_q};
        dv_start = (rep_q != '0) && !dv_st.busy && !dv_st.done;
      end
      pn2d_pkg::StMixA: begin
        ma = $signed({1'b0, ccx[31:0]}); mb = $signed({1'b0, pn2d_pkg::Mix1});
      end
      pn2d_pkg::StMixB: begin
        ma = $signed({1'b0, hb_q}); mb = $signed({1'b0, pn2d_pkg::Mix2});
      end
      pn2d_pkg::StMixC: begin
        ma = $signed({1'b0, ha_q}); mb = $signed({1'b0, pn2d_pkg::Mix3});
      end
      pn2d_pkg::StFadeA, pn2d_pkg::StFadeB: begin
        if (sub_q == 2'd0) begin
          ma = $signed({17'b0, (st_q == pn2d_pkg::StFadeA) ? tx : ty}); mb = ma;
        end else begin
          ma = t2_q[32:0];
          mb = 33'sd196608 - $signed({16'b0, (st_q == pn2d_pkg::StFadeA) ? tx : ty, 1'b0});
        end
      end
      pn2d_pkg::StLerpA: begin
        ma = $signed(dot[1]) - $signed(dot[0]); mb = ft_q[32:0];
      end
      pn2d_pkg::StLerpB: begin
        ma = $signed(dot[3]) - $signed(dot[2]); mb = ft_q[32:0];
      end
      pn2d_pkg::StLerpC: begin
        ma = hi_q[32:0] - lo_q[32:0]; mb = fty_q[32:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pn2d_pkg::StIdle; seed_q <= '0; rep_q <= '0; out_v_q <= 1'b0;
      sub_q <= '0; cnt_q <= '0; corner_q <= '0;
    end else begin
      st_q <= st_d;
      if (wr_en_i) begin
        if (wr_idx_i == pn2d_pkg::RegSeed) seed_q <= wr_data_i;
        else rep_q <= wr_data_i[16:0];
      end
      if (m_axis_tready) out_v_q <= 1'b0;
      if (st_q == pn2d_pkg::StDone) out_v_q <= 1'b1;
      if (st_d != st_q) sub_q <= '0;
      else if (!(st_q == pn2d_pkg::StModStep ||
                 st_q == pn2d_pkg::StWrapX || st_q == pn2d_pkg::StWrapY) || dv_st.done)
        sub_q <= sub_q + 2'd1;
      unique case (st_q)
        pn2d_pkg::StIdle: begin
          cnt_q <= '0; corner_q <= '0;
        end
        pn2d_pkg::StFill:  cnt_q <= (cnt_q == 9'd255) ? 9'd256 : cnt_q + 9'd1;
        pn2d_pkg::StSwap:  cnt_q <= cnt_q - 9'd1;
        pn2d_pkg::StRd3:   corner_q <= corner_q + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      pn2d_pkg::StIdle: begin
        x_q <= s_axis_tdata[31:0]; y_q <= s_axis_tdata[63:32];
        req_q <= s_axis_tuser;
        cx_q <= {{17{s_axis_tdata[31]}}, s_axis_tdata[31:16]};
        cy_q <= {{17{s_axis_tdata[63]}}, s_axis_tdata[63:48]};
        lcg_q <= (seed_m2 == '0) ? 32'd1 : seed_m2;
        k_q <= '0;
      end
      pn2d_pkg::StFill: pool[cnt_q[7:0]] <= cnt_q[7:0];
      pn2d_pkg::StLcgRed: lcg_q <= lcg_next;
      pn2d_pkg::StModStep: if (dv_st.done) r_q <= dv_rem[7:0];
      pn2d_pkg::StPick: begin
        pool_rd_q <= pool[r_q];
        pool_last_q <= pool[8'(cnt_q - 9'd1)];
      end
      pn2d_pkg::StSwap: begin
        perm[k_q] <= pool_rd_q;
        pool[r_q] <= pool_last_q;
        k_q <= k_q + 8'd1;
      end
      pn2d_pkg::StWrapX, pn2d_pkg::StWrapY: begin
        if (dv_start) wrap_neg_q <= wrap_src[32];
        if (rep_q == '0) begin
          if (st_q == pn2d_pkg::StWrapX) begin
            lx_q <= cx_q; rx_q <= cx_q + 33'sd1;
          end else begin
            ly_q <= cy_q; uy_q <= cy_q + 33'sd1;
          end
        end else if (dv_st.done) begin
          if (st_q == pn2d_pkg::StWrapX) begin
            if (sub_q == 2'd0) lx_q <= wrap_res; else rx_q <= wrap_res;
          end else begin
            if (sub_q == 2'd0) ly_q <= wrap_res; else uy_q <= wrap_res;
          end
        end
      end
      pn2d_pkg::StMixA: if (sub_q == 2'd1) begin
        ha_q <= mp[31:0];
        hb_q <= ccy[31:0] ^ pn2d_pkg::rot16(mp[31:0]);
      end
      pn2d_pkg::StMixB: if (sub_q == 2'd1) begin
        hb_q <= mp[31:0];
        ha_q <= ha_q ^ pn2d_pkg::rot16(mp[31:0]);
      end
      pn2d_pkg::StMixC: if (sub_q == 2'd1) ha_q <= mp[31:0];
      pn2d_pkg::StRd0: prd_q <= perm[ha_q[7:0]];
      pn2d_pkg::StRd1: idx_q <= prd_q + hb_q[7:0];
      pn2d_pkg::StRd2: prd_q <= perm[idx_q];
      pn2d_pkg::StRd3: grad_q[corner_q] <= perm[prd_q][1:0];
      pn2d_pkg::StFadeA, pn2d_pkg::StFadeB: begin
        if (sub_q == 2'd1) t2_q <= 34'(mp >>> 16);
        if (sub_q == 2'd3) begin
          if (st_q == pn2d_pkg::StFadeA) ft_q <= 34'(mp >>> 16);
          else fty_q <= 34'(mp >>> 16);
        end
      end
      pn2d_pkg::StLerpA: if (sub_q == 2'd1) lo_q <= 34'($signed(dot[0])) + 34'(mp >>> 16);
      pn2d_pkg::StLerpB: if (sub_q == 2'd1) hi_q <= 34'($signed(dot[2])) + 34'(mp >>> 16);
      pn2d_pkg::StLerpC: if (sub_q == 2'd1) v_q <= lo_q + 34'(mp >>> 16);
      pn2d_pkg::StDone: begin
        out_built_q <= (req_q == pn2d_pkg::ReqBuild);
        if (req_q == pn2d_pkg::ReqBuild) out_q <= '0;
        else if (v_q > 34'sd131071) out_q <= 18'h1ffff;
        else if (v_q < -34'sd131072) out_q <= 18'h20000;
        else out_q <= v_q[17:0];
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (st_q == pn2d_pkg::StIdle) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_q};
  assign m_axis_tuser  = out_built_q;
  logic unused;
  assign unused = ^{dx, dy};
endmodule
`default_nettype wire

// ----- rtl/core/pn2d_checker.sv -----
// port-level checker for the noise sampler, bound to the top level
// depends on perlin_noise_2d_sampler_top ports only
`timescale 1ns / 1ps
`default_nettype none
module pn2d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'b0) else $error("pad bits set");
  a_build_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == 24'b0) else $error("build nonzero");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");
endmodule

bind perlin_noise_2d_sampler_top pn2d_checker u_pn2d_checker (.*);
`default_nettype wire
